// ===== design/ccs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and character constants for the comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [8:0] {
        LX_NORMAL    = 9'b000000001,
        LX_SLASH     = 9'b000000010,
        LX_LINE      = 9'b000000100,
        LX_BLOCK     = 9'b000001000,
        LX_BLOCKSTAR = 9'b000010000,
        LX_STR       = 9'b000100000,
        LX_STR_ESC   = 9'b001000000,
        LX_CHR       = 9'b010000000,
        LX_CHR_ESC   = 9'b100000000
    } t_lex;

    // One classified input: zero, one or two bytes to emit, plus end flag.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] n_bytes;
        logic       eot;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/ccs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front
// Lexer front end: tracks the lexical mode and turns each byte into a command.
// ----------------------------------------------------------------------------
module ccs_front
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    input  t_q_status  i_q_status,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_lex r_lex;
    t_lex n_lex;
    t_cmd w_cmd;
    logic w_accept;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !i_q_status.full;

    always_comb begin
        n_lex         = r_lex;
        w_cmd.byte0   = i_in_byte;
        w_cmd.byte1   = i_in_byte;
        w_cmd.n_bytes = 2'd0;
        w_cmd.eot     = i_is_last;
        case (r_lex)
            LX_SLASH: begin
                if (i_in_byte == CH_SLASH) begin
                    n_lex = LX_LINE;
                end else if (i_in_byte == CH_STAR) begin
                    n_lex = LX_BLOCK;
                end else begin
                    w_cmd.byte0   = CH_SLASH;
                    w_cmd.n_bytes = 2'd2;
                    if (i_in_byte == CH_DQUOTE) begin
                        n_lex = LX_STR;
                    end else if (i_in_byte == CH_SQUOTE) begin
                        n_lex = LX_CHR;
                    end else begin
                        n_lex = LX_NORMAL;
                    end
                end
            end
            LX_LINE: begin
                if (i_in_byte == CH_NL) begin
                    w_cmd.n_bytes = 2'd1;
                    n_lex         = LX_NORMAL;
                end
            end
            LX_BLOCK: begin
                if (i_in_byte == CH_STAR) begin
                    n_lex = LX_BLOCKSTAR;
                end
            end
            LX_BLOCKSTAR: begin
                if (i_in_byte == CH_SLASH) begin
                    n_lex = LX_NORMAL;
                end else if (i_in_byte != CH_STAR) begin
                    n_lex = LX_BLOCK;
                end
            end
            LX_STR: begin
                w_cmd.n_bytes = 2'd1;
                if (i_in_byte == CH_BSLASH) begin
                    n_lex = LX_STR_ESC;
                end else if (i_in_byte == CH_DQUOTE) begin
                    n_lex = LX_NORMAL;
                end
            end
            LX_STR_ESC: begin
                w_cmd.n_bytes = 2'd1;
                n_lex         = LX_STR;
            end
            LX_CHR: begin
                w_cmd.n_bytes = 2'd1;
                if (i_in_byte == CH_BSLASH) begin
                    n_lex = LX_CHR_ESC;
                end else if (i_in_byte == CH_SQUOTE) begin
                    n_lex = LX_NORMAL;
                end
            end
            LX_CHR_ESC: begin
                w_cmd.n_bytes = 2'd1;
                n_lex         = LX_CHR;
            end
            default: begin
                if (i_in_byte == CH_SLASH) begin
                    n_lex = LX_SLASH;
                end else begin
                    w_cmd.n_bytes = 2'd1;
                    if (i_in_byte == CH_DQUOTE) begin
                        n_lex = LX_STR;
                    end else if (i_in_byte == CH_SQUOTE) begin
                        n_lex = LX_CHR;
                    end else begin
                        n_lex = LX_NORMAL;
                    end
                end
            end
        endcase
        if (i_is_last) begin
            // release a held slash; no other byte was emitted in that case
            if (n_lex == LX_SLASH) begin
                w_cmd.byte0   = CH_SLASH;
                w_cmd.n_bytes = 2'd1;
            end
            n_lex = LX_NORMAL;
        end
    end

    assign o_push = w_accept && ((w_cmd.n_bytes != 2'd0) || i_is_last);
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex <= LX_NORMAL;
        end else if (w_accept) begin
            r_lex <= n_lex;
        end
    end

endmodule

// ===== design/ccs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_queue
// Short command queue between the lexer front end and the output back end.
// ----------------------------------------------------------------------------
module ccs_queue
    import ccs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/ccs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_back
// Output back end: serializes queued commands into single-byte results.
// ----------------------------------------------------------------------------
module ccs_back
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_text
);

    logic       r_valid,     n_valid;
    logic [7:0] r_out_byte,  n_out_byte;
    logic       r_byte_vld,  n_byte_vld;
    logic       r_eot,       n_eot;
    logic       r_pend,      n_pend;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic       r_pend_eot,  n_pend_eot;
    logic       w_adv;

    assign w_adv = !r_valid || !i_stall;

    always_comb begin
        n_valid     = r_valid;
        n_out_byte  = r_out_byte;
        n_byte_vld  = r_byte_vld;
        n_eot       = r_eot;
        n_pend      = r_pend;
        n_pend_byte = r_pend_byte;
        n_pend_eot  = r_pend_eot;
        o_pop       = 1'b0;
        if (w_adv) begin
            if (r_pend) begin
                n_valid    = 1'b1;
                n_out_byte = r_pend_byte;
                n_byte_vld = 1'b1;
                n_eot      = r_pend_eot;
                n_pend     = 1'b0;
            end else if (!i_q_status.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_cmd.n_bytes == 2'd0) begin
                    n_out_byte = 8'h00;
                    n_byte_vld = 1'b0;
                    n_eot      = i_cmd.eot;
                end else begin
                    n_out_byte = i_cmd.byte0;
                    n_byte_vld = 1'b1;
                    n_eot      = i_cmd.eot && (i_cmd.n_bytes == 2'd1);
                end
                n_pend      = (i_cmd.n_bytes == 2'd2);
                n_pend_byte = i_cmd.byte1;
                n_pend_eot  = i_cmd.eot;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_byte_vld  <= n_byte_vld;
        r_eot       <= n_eot;
        r_pend_byte <= n_pend_byte;
        r_pend_eot  <= n_pend_eot;
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_vld;
    assign o_end_of_text = r_eot;

endmodule

// ===== design/c_comment_stripper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper
// Removes C line and block comments from a byte stream, literals untouched.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      i_valid / o_stall    i_in_byte, i_is_last
//  out      output     o_valid / i_stall    o_out_byte, o_byte_valid, o_end_of_text
//
//  One input byte is taken per cycle unless o_stall is high; the lexer mode
//  updates in that cycle. Results leave one per cycle from the output register
//  unless i_stall is high, two for an input that releases a held slash together
//  with the next byte. Each passes the command queue, then the output register.
//  Reset (synchronous, low) returns to normal text and empties the queue.
//  o_stall rises when the QUEUE_DEPTH-entry command queue is full.
// ----------------------------------------------------------------------------
module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_text
);

    t_q_status w_q_status;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    logic      w_push;
    logic      w_pop;

    ccs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_is_last  (i_is_last),
        .i_q_status (w_q_status),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    ccs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_end_of_text (o_end_of_text)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty at once");

    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_end_of_text && (o_out_byte == 8'h00)))
        else $error("end marker without end of text");

    a_fill_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_q_status.full) |-> $past(w_push))
        else $error("queue filled without a push");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for c_comment_stripper. Feeds directed and random
// C-like text with random idle cycles on both channels, predicts the stripped
// stream in a scoreboard and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ccs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_CYCLES  = 80;
    localparam int BURST_BYTES  = 40;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] text;
        logic       has_byte;
        logic       eot;
    } t_kept;

    class comment_strip_model;
        t_lex  mode = LX_NORMAL;
        t_kept kept_q[$];
        int    errors = 0;
        int    step_count = 0;

        function void keep(logic [7:0] c);
            t_kept k;
            k.text = c;
            k.has_byte = 1'b1;
            k.eot = 1'b0;
            kept_q.push_back(k);
            step_count++;
        endfunction

        function void plain_byte(logic [7:0] c);
            if (c == CH_SLASH) begin
                mode = LX_SLASH;
            end else if (c == CH_DQUOTE) begin
                keep(c);
                mode = LX_STR;
            end else if (c == CH_SQUOTE) begin
                keep(c);
                mode = LX_CHR;
            end else begin
                keep(c);
                mode = LX_NORMAL;
            end
        endfunction

        function void take_source_byte(logic [7:0] c, logic last);
            t_kept k;
            step_count = 0;
            case (mode)
                LX_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode = LX_LINE;
                    end else if (c == CH_STAR) begin
                        mode = LX_BLOCK;
                    end else begin
                        keep(CH_SLASH);
                        plain_byte(c);
                    end
                end
                LX_LINE: begin
                    if (c == CH_NL) begin
                        keep(c);
                        mode = LX_NORMAL;
                    end
                end
                LX_BLOCK: begin
                    if (c == CH_STAR) mode = LX_BLOCKSTAR;
                end
                LX_BLOCKSTAR: begin
                    if (c == CH_SLASH) mode = LX_NORMAL;
                    else if (c != CH_STAR) mode = LX_BLOCK;
                end
                LX_STR: begin
                    keep(c);
                    if (c == CH_BSLASH) mode = LX_STR_ESC;
                    else if (c == CH_DQUOTE) mode = LX_NORMAL;
                end
                LX_STR_ESC: begin
                    keep(c);
                    mode = LX_STR;
                end
                LX_CHR: begin
                    keep(c);
                    if (c == CH_BSLASH) mode = LX_CHR_ESC;
                    else if (c == CH_SQUOTE) mode = LX_NORMAL;
                end
                LX_CHR_ESC: begin
                    keep(c);
                    mode = LX_CHR;
                end
                default: begin
                    plain_byte(c);
                end
            endcase
            if (last) begin
                if (mode == LX_SLASH) keep(CH_SLASH);
                if (step_count == 0) begin
                    k = '0;
                    k.eot = 1'b1;
                    kept_q.push_back(k);
                end else begin
                    kept_q[kept_q.size() - 1].eot = 1'b1;
                end
                mode = LX_NORMAL;
            end
        endfunction

        function void check_stripped(logic [7:0] text, logic has_byte, logic eot);
            t_kept k;
            if (kept_q.size() == 0) begin
                $error("unexpected result: out_byte %02h byte_valid %0b end_of_text %0b",
                       text, has_byte, eot);
                errors++;
                return;
            end
            k = kept_q.pop_front();
            if (text !== k.text) begin
                $error("out_byte: expected %02h, actual %02h", k.text, text);
                errors++;
            end
            if (has_byte !== k.has_byte) begin
                $error("byte_valid: expected %0b, actual %0b", k.has_byte, has_byte);
                errors++;
            end
            if (eot !== k.eot) begin
                $error("end_of_text: expected %0b, actual %0b", k.eot, eot);
                errors++;
            end
        endfunction

        function int pending();
            return kept_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_is_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_end_of_text;

    comment_strip_model strip_model;
    logic [7:0] text_q[$];
    int  cycle_count = 0;
    int  items_sent = 0;
    int  send_calm = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    c_comment_stripper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_end_of_text (o_end_of_text)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && !o_stall) strip_model.take_source_byte(i_in_byte, i_is_last);
            if (o_valid && !i_stall) begin
                strip_model.check_stripped(o_out_byte, o_byte_valid, o_end_of_text);
            end
        end
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == x0 || b == x1 || b == x2);
        return b;
    endfunction

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_is_last <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_text(input bit no_gaps);
        int gap;
        for (int k = 0; k < text_q.size(); k++) begin
            gap = no_gaps ? 0 : draw_wait(send_calm);
            send_byte(text_q[k], k == text_q.size() - 1, gap);
        end
        items_sent += text_q.size();
        text_q.delete();
    endtask

    task automatic drain_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (strip_model.pending() != 0) @(posedge i_clk);
    endtask

    task automatic build_random_text();
        int n_tok;
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) begin
                        text_q.push_back(pick_other(CH_SLASH, CH_DQUOTE, CH_SQUOTE));
                    end
                end
                2: begin
                    add_str("//");
                    repeat ($urandom_range(0, 8)) text_q.push_back(pick_other(CH_NL, CH_NL, CH_NL));
                    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_BSLASH);
                    text_q.push_back(CH_NL);
                end
                3, 4: begin
                    add_str("/*");
                    repeat ($urandom_range(0, 8)) begin
                        if ($urandom_range(0, 3) == 0) text_q.push_back(CH_STAR);
                        else text_q.push_back(pick_other(CH_STAR, CH_SLASH, CH_STAR));
                    end
                    repeat ($urandom_range(1, 3)) text_q.push_back(CH_STAR);
                    text_q.push_back(CH_SLASH);
                end
                5: begin
                    text_q.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        if ($urandom_range(0, 4) == 0) begin
                            text_q.push_back(CH_BSLASH);
                            text_q.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            text_q.push_back(pick_other(CH_DQUOTE, CH_BSLASH, CH_BSLASH));
                        end
                    end
                    text_q.push_back(CH_DQUOTE);
                end
                6: begin
                    text_q.push_back(CH_SQUOTE);
                    if ($urandom_range(0, 2) == 0) begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        text_q.push_back(pick_other(CH_SQUOTE, CH_BSLASH, CH_BSLASH));
                    end
                    text_q.push_back(CH_SQUOTE);
                end
                7: begin
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(pick_other(CH_SLASH, CH_STAR, CH_STAR));
                end
                8: begin
                    repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: text_q.push_back(CH_SLASH);
                        1: text_q.push_back(CH_STAR);
                        2: text_q.push_back(CH_DQUOTE);
                        3: text_q.push_back(CH_SQUOTE);
                        4: text_q.push_back(CH_BSLASH);
                        default: text_q.push_back(CH_NL);
                    endcase
                end
            endcase
        end
    endtask

    // receiver: random stall per result, one long hold on request
    initial begin
        int gap;
        int calm;
        calm = 0;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = draw_wait(calm);
            end
            if (gap > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int target;
        strip_model = new;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = 8'h00;
        i_is_last = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // byte extremes, slash held at end of text
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_SLASH);
        send_text(1'b0);
        // slash released before a char literal with an escaped quote
        add_str("/'\\''");
        send_text(1'b0);
        // backslash-newline ends a line comment
        add_str("//\\\n");
        send_text(1'b0);
        // opening star does not close, star run closes; empty last step
        add_str("/*/**/");
        send_text(1'b0);
        // escaped quote and comment opener inside a string
        add_str("\"\\\"/*\"");
        send_text(1'b0);
        // block comment cut off at end
        add_str("/*");
        send_text(1'b0);
        drain_results();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            build_random_text();
            send_text(1'b0);
            if (!hold_done && items_sent > target - RANDOM_ITEMS / 2) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                repeat (BURST_BYTES) begin
                    text_q.push_back(pick_other(CH_SLASH, CH_DQUOTE, CH_SQUOTE));
                end
                send_text(1'b1);
            end
            if ($urandom_range(0, 19) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (strip_model.errors == 0 && strip_model.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ccs_pkg.sv
design/ccs_front.sv
design/ccs_queue.sv
design/ccs_back.sv
design/c_comment_stripper.sv
bench/tb_top.sv
